// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl file frame_rate_moving_average
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== sv/frma_pkg.sv =====
// types, constants and state codes of the frame rate meter
// no dependencies
`default_nettype none

package frma_pkg;

    localparam int TS_W           = 32;
    localparam int TPS_W          = 30;
    localparam int RATE_W         = 24;
    localparam int FRAC_W         = 8;
    localparam int WINDOW_DEFAULT = 64;

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000000);

    typedef struct packed {
        logic [TS_W-1:0] timestamp;
    } t_frame_in;

    typedef struct packed {
        logic [RATE_W-1:0] rate_q8;
        logic [TS_W-1:0]   average_interval;
    } t_frame_out;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_ring_ctrl;

    typedef struct packed {
        logic full;
    } t_ring_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_ADD,
        S_SUB,
        S_DIV1,
        S_DIV1_WAIT,
        S_DIV2,
        S_DIV2_WAIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/frma_stream_if.sv =====
// valid/ready channel carrying one request payload
// payload type given by the instantiating level
`default_nettype none

interface frma_stream_if #(
    parameter type T_DATA = logic
) ();
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/frma_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on frma_pkg
`default_nettype none

module frma_div #(
    parameter int DIV_W = 38,
    parameter int DSR_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_quotient
);
    import frma_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DIV_W-1:0] r_shift;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   w_trial;
    logic [DSR_W:0]   w_diff;
    logic             w_qbit;

    assign w_trial = {r_rem, r_shift[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_qbit  = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_dsr   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_shift <= {r_shift[DIV_W-2:0], w_qbit};
            r_rem   <= w_qbit ? w_diff[DSR_W-1:0] : w_trial[DSR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_shift;

endmodule

`default_nettype wire

// ===== sv/frma_ring.sv =====
// ring of the last WINDOW intervals with write slot and fill count
// depends on frma_pkg
`default_nettype none

module frma_ring #(
    parameter int WINDOW = 64,
    parameter int DATA_W = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire frma_pkg::t_ring_ctrl         i_ctrl,
    input  wire logic [DATA_W-1:0]            i_wdata,
    output logic      [DATA_W-1:0]            o_rdata,
    output frma_pkg::t_ring_stat              o_stat,
    output logic      [$clog2(WINDOW+1)-1:0]  o_count
);
    import frma_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    logic [DATA_W-1:0] r_mem [WINDOW];
    logic [DATA_W-1:0] r_rdata;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_mem[r_slot] <= i_wdata;
        end
        if (i_ctrl.rd) begin
            r_rdata <= r_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
        end else if (i_ctrl.wr) begin
            r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
            if (r_count != CNT_W'(WINDOW)) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_rdata     = r_rdata;
    assign o_count     = r_count;
    assign o_stat.full = (r_count == CNT_W'(WINDOW));

endmodule

`default_nettype wire

// ===== sv/frame_rate_moving_average.sv =====
// Frame rate meter. Each request on i_frame carries a tick timestamp; the block
// forms the interval since the previous one (the first from zero, wrapping modulo
// 2^32), keeps the last WINDOW intervals in a ring with a running sum, and returns
// on o_rate the mean interval (sum / intervals held) and the rate
// ticks_per_second * 256 / mean as unsigned Q16.8, saturated to all ones when
// the mean is zero or the quotient does not fit. One request is processed at a
// time: i_frame is ready only while the block is idle.
// Both quotients come from one bit-serial divider of width DIV_W, the larger of
// 38 and 32 + log2(WINDOW), that retires one bit a cycle. The ring needs no
// clearing after reset. The user writes ticks_per_second through i_cfg_we /
// i_cfg_wdata only while no request is in flight; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module frame_rate_moving_average #(
    parameter int WINDOW = frma_pkg::WINDOW_DEFAULT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    frma_stream_if.sink                   i_frame,
    frma_stream_if.source                 o_rate,
    input  wire logic                     i_cfg_we,
    input  wire logic [frma_pkg::TPS_W-1:0] i_cfg_wdata
);
    import frma_pkg::*;

    localparam int SUM_W = TS_W + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int NUM_W = TPS_W + FRAC_W;
    localparam int DIV_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;

    t_state            r_state, n_state;
    logic [TPS_W-1:0]  r_tps;
    logic [TS_W-1:0]   r_prev, n_prev;
    logic [TS_W-1:0]   r_interval, n_interval;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_was_full, n_was_full;
    logic [TS_W-1:0]   r_avg, n_avg;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic              r_out_valid, n_out_valid;
    t_frame_out        r_out, n_out;

    t_ring_ctrl        w_ring_ctrl;
    t_ring_stat        w_ring_stat;
    logic [TS_W-1:0]   w_ring_rdata;
    logic [CNT_W-1:0]  w_ring_count;

    logic              w_div_start;
    logic [DIV_W-1:0]  w_div_dividend;
    logic [TS_W-1:0]   w_div_divisor;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_div_quo;
    logic              w_rate_sat;

    frma_ring #(
        .WINDOW (WINDOW),
        .DATA_W (TS_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ring_ctrl),
        .i_wdata (r_interval),
        .o_rdata (w_ring_rdata),
        .o_stat  (w_ring_stat),
        .o_count (w_ring_count)
    );

    frma_div #(
        .DIV_W (DIV_W),
        .DSR_W (TS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign i_frame.ready = (r_state == S_IDLE);
    assign o_rate.valid  = r_out_valid;
    assign o_rate.data   = r_out;

    assign w_rate_sat = (r_avg == '0) || (|w_div_quo[DIV_W-1:RATE_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tps       <= TPS_RESET;
            r_prev      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_interval <= n_interval;
        r_was_full <= n_was_full;
        r_avg      <= n_avg;
        r_rate     <= n_rate;
        r_out      <= n_out;
    end

    always_comb begin
        n_state        = r_state;
        n_prev         = r_prev;
        n_interval     = r_interval;
        n_sum          = r_sum;
        n_was_full     = r_was_full;
        n_avg          = r_avg;
        n_rate         = r_rate;
        n_out          = r_out;
        n_out_valid    = r_out_valid && !o_rate.ready;
        w_ring_ctrl    = '0;
        w_div_start    = 1'b0;
        w_div_dividend = DIV_W'(r_sum);
        w_div_divisor  = TS_W'(w_ring_count);

        unique case (r_state)
            S_IDLE: begin
                if (i_frame.valid) begin
                    n_interval     = i_frame.data.timestamp - r_prev;
                    n_prev         = i_frame.data.timestamp;
                    w_ring_ctrl.rd = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                n_was_full = w_ring_stat.full;
                n_state    = S_ADD;
            end
            S_ADD: begin
                n_sum          = r_sum + SUM_W'(r_interval);
                w_ring_ctrl.wr = 1'b1;
                n_state        = S_SUB;
            end
            S_SUB: begin
                if (r_was_full) begin
                    n_sum = r_sum - SUM_W'(w_ring_rdata);
                end
                n_state = S_DIV1;
            end
            S_DIV1: begin
                w_div_start = 1'b1;
                n_state     = S_DIV1_WAIT;
            end
            S_DIV1_WAIT: begin
                if (w_div_done) begin
                    n_avg   = w_div_quo[TS_W-1:0];
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                w_div_start    = 1'b1;
                w_div_dividend = DIV_W'({r_tps, {FRAC_W{1'b0}}});
                w_div_divisor  = r_avg;
                n_state        = S_DIV2_WAIT;
            end
            S_DIV2_WAIT: begin
                if (w_div_done) begin
                    n_rate  = w_rate_sat ? '1 : w_div_quo[RATE_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rate.ready) begin
                    n_out.rate_q8          = r_rate;
                    n_out.average_interval = r_avg;
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks on the datapath and sequencing

    `ASSERT_CLK(a_count_bounded, i_clk, i_rst_n, w_ring_count <= CNT_W'(WINDOW))

    `ASSERT_CLK(a_div_done_waited, i_clk, i_rst_n, w_div_done |-> (r_state == S_DIV1_WAIT || r_state == S_DIV2_WAIT))

    `ASSERT_CLK(a_zero_avg_saturates, i_clk, i_rst_n, (r_out_valid && r_out.average_interval == '0) |-> (r_out.rate_q8 == '1))

    `ASSERT_NEVER(a_no_div_start_busy, i_clk, i_rst_n, w_div_start && (r_state == S_DIV1_WAIT || r_state == S_DIV2_WAIT))

endmodule

`default_nettype wire
